@@ design/lsfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfp_pkg: shared definitions for the line sensor frame parser
// Frame store sizing, fixed-point widths, frame characters, register indexes
// and the sequencer state types.
// ----------------------------------------------------------------------------
package lsfp_pkg;

	// frame store
	localparam int FRAME_DEPTH = 64;
	localparam int AW          = $clog2(FRAME_DEPTH);
	localparam int FULL_LEN    = FRAME_DEPTH - 1;

	// fixed point
	localparam int FRAC_BITS   = 8;
	localparam int NUM_W       = FRAC_BITS + 5;
	localparam int DCNT_W      = $clog2(NUM_W);
	localparam int ERR_W       = 12;
	localparam int LIM_W       = 11;
	localparam int HOLD_THRESH = (1 << FRAC_BITS) / 100;
	localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(7 << FRAC_BITS);

	// channel weights, channel 0 first
	localparam logic signed [3:0] CHAN_WEIGHT [8] = '{
		-4'sd7, -4'sd5, -4'sd3, -4'sd1, 4'sd1, 4'sd3, 4'sd5, 4'sd7
	};

	// configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = LIM_W;
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT = 8'd1;

	// frame characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_D      = 8'h44;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_CALC = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_POST = 5'b10000
	} state_t;

	typedef enum logic [5:0] {
		MD_HDR0  = 6'b000001,
		MD_HDR1  = 6'b000010,
		MD_COMMA = 6'b000100,
		MD_COLON = 6'b001000,
		MD_DIGIT = 6'b010000,
		MD_SEP   = 6'b100000
	} scan_mode_t;

endpackage

@@ design/lsfp_ram.sv @@
// ----------------------------------------------------------------------------
// lsfp_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lsfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/line_sensor_frame_parser_top.sv @@
// ----------------------------------------------------------------------------
// line_sensor_frame_parser_top: serial line sensor frame parser
// Ordinary byte: ST_CALC, then the 13-step restoring divider (ST_DIV), then ST_POST;
// ST_CALC goes straight to ST_POST (line lost) if no channel is black. A '#' byte
// first runs a store scan, one stored byte read per cycle, up to the stored length.
// ST_POST loads the result once the output register is free; one byte is in work
// at a time, s_tready is high only when idle, so the next byte can be taken in the cycle
// after the result loads. Reset clears control state, channel levels, held error and
// config to defaults; frame store contents are not cleared.
// ----------------------------------------------------------------------------
module line_sensor_frame_parser_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // rx_byte
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [23:0]                      m_tdata,   // sensor_bits, position_error, pad
	output logic                             m_tuser,   // line_lost
	output logic                             m_tlast,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lsfp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lsfp_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lsfp_pkg::state_t     state_q;
	lsfp_pkg::scan_mode_t mode_q;
	lsfp_pkg::scan_mode_t mode_d;

	logic [lsfp_pkg::AW-1:0]     len_q;
	logic [lsfp_pkg::AW-1:0]     scan_len_q;
	logic [lsfp_pkg::AW-1:0]     issue_q;
	logic [lsfp_pkg::AW-1:0]     len_eff;
	logic [lsfp_pkg::AW-1:0]     len_new;
	logic                        store_ok;
	logic                        s_acc;
	logic                        rd_en;
	logic                        rd_vld_s1;
	logic [7:0]                  rd_data;
	logic [2:0]                  ch_q;
	logic                        ch_inc;
	logic                        ev_stop;
	logic [7:0]                  levels_q;
	logic [7:0]                  lvl_d;
	logic                        black_q;
	logic [lsfp_pkg::LIM_W-1:0]  limit_q;
	logic signed [lsfp_pkg::ERR_W-1:0] held_q;
	logic                        neg_q;
	logic                        lost_q;
	logic                        ended_q;

	// centroid terms
	logic [7:0]                  blk;
	logic signed [5:0]           wsum;
	logic [3:0]                  bcount;
	logic [5:0]                  wsum_abs;

	// divider
	logic [3:0]                  div_den_q;
	logic [3:0]                  rem_q;
	logic [lsfp_pkg::NUM_W-1:0]  quot_q;
	logic [lsfp_pkg::DCNT_W-1:0] div_cnt_q;
	logic [4:0]                  trial;
	logic                        trial_ge;
	logic [4:0]                  trial_sub;

	// result
	logic [lsfp_pkg::NUM_W-1:0]  lim_ext;
	logic [lsfp_pkg::NUM_W-1:0]  mag_c;
	logic [lsfp_pkg::ERR_W-1:0]  err_mag;
	logic signed [lsfp_pkg::ERR_W-1:0] err_val;
	logic signed [lsfp_pkg::ERR_W-1:0] res_err;
	logic                        out_load;
	logic                        m_tvalid_q;
	logic [23:0]                 m_tdata_q;
	logic                        m_tuser_q;
	logic                        m_tlast_q;
	logic signed [lsfp_pkg::ERR_W-1:0] out_err;
	logic [lsfp_pkg::ERR_W-1:0]  out_err_mag;

	assign s_tready  = (state_q == lsfp_pkg::ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign m_tlast   = m_tlast_q;

	// frame store write
	assign len_eff  = (s_tdata == lsfp_pkg::CH_DOLLAR) ? '0 : len_q;
	assign store_ok = (len_eff != lsfp_pkg::AW'(lsfp_pkg::FULL_LEN));
	assign len_new  = store_ok ? len_eff + 1'b1 : len_eff;
	assign rd_en    = (state_q == lsfp_pkg::ST_SCAN) && (issue_q != scan_len_q);

	lsfp_ram #(
		.WIDTH (8),
		.DEPTH (lsfp_pkg::FRAME_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (s_acc && store_ok),
		.waddr (len_eff),
		.wdata (s_tdata),
		.re    (rd_en),
		.raddr (issue_q),
		.rdata (rd_data)
	);

	// frame parse, one stored byte per cycle
	always_comb begin
		ev_stop = 1'b0;
		mode_d  = mode_q;
		lvl_d   = levels_q;
		ch_inc  = 1'b0;
		if (rd_data == lsfp_pkg::CH_NUL) begin
			ev_stop = 1'b1;
		end else begin
			unique case (mode_q)
				lsfp_pkg::MD_HDR0: begin
					if (rd_data == lsfp_pkg::CH_DOLLAR) mode_d = lsfp_pkg::MD_HDR1;
					else ev_stop = 1'b1;
				end
				lsfp_pkg::MD_HDR1: begin
					if (rd_data == lsfp_pkg::CH_D) mode_d = lsfp_pkg::MD_COMMA;
					else ev_stop = 1'b1;
				end
				lsfp_pkg::MD_COMMA: begin
					if (rd_data == lsfp_pkg::CH_COMMA) mode_d = lsfp_pkg::MD_COLON;
				end
				lsfp_pkg::MD_COLON: begin
					if (rd_data == lsfp_pkg::CH_COLON) mode_d = lsfp_pkg::MD_DIGIT;
				end
				lsfp_pkg::MD_DIGIT: begin
					priority if (rd_data == lsfp_pkg::CH_ZERO) begin
						lvl_d[ch_q] = 1'b0;
					end else if (rd_data == lsfp_pkg::CH_ONE) begin
						lvl_d[ch_q] = 1'b1;
					end else begin
						ev_stop = 1'b1;
					end
					if (!ev_stop) begin
						if (ch_q == 3'd7) begin
							ev_stop = 1'b1;
						end else begin
							mode_d = lsfp_pkg::MD_SEP;
							ch_inc = 1'b1;
						end
					end
				end
				lsfp_pkg::MD_SEP: begin
					if (rd_data == lsfp_pkg::CH_COMMA) mode_d = lsfp_pkg::MD_COLON;
				end
				default: ev_stop = 1'b1;
			endcase
		end
	end

	// weight sum and black count
	always_comb begin
		blk    = black_q ? levels_q : ~levels_q;
		wsum   = '0;
		bcount = '0;
		for (int i = 0; i < 8; i++) begin
			if (blk[i]) begin
				wsum   = wsum + 6'(lsfp_pkg::CHAN_WEIGHT[i]);
				bcount = bcount + 4'd1;
			end
		end
		wsum_abs = (wsum < 0) ? 6'(-wsum) : 6'(wsum);
	end

	// restoring divide step
	assign trial     = {rem_q, quot_q[lsfp_pkg::NUM_W-1]};
	assign trial_ge  = (trial >= {1'b0, div_den_q});
	assign trial_sub = trial - {1'b0, div_den_q};

	// clamp and sign
	assign lim_ext  = lsfp_pkg::NUM_W'(limit_q);
	assign mag_c    = (quot_q > lim_ext) ? lim_ext : quot_q;
	assign err_mag  = lsfp_pkg::ERR_W'(mag_c);
	assign err_val  = neg_q ? -$signed(err_mag) : $signed(err_mag);
	assign res_err  = lost_q ? held_q : err_val;
	assign out_load = (state_q == lsfp_pkg::ST_POST) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lsfp_pkg::ST_IDLE;
			mode_q     <= lsfp_pkg::MD_HDR0;
			len_q      <= '0;
			scan_len_q <= '0;
			issue_q    <= '0;
			rd_vld_s1  <= 1'b0;
			ch_q       <= '0;
			levels_q   <= '0;
			black_q    <= 1'b0;
			limit_q    <= lsfp_pkg::LIMIT_RESET;
			held_q     <= '0;
			neg_q      <= 1'b0;
			lost_q     <= 1'b0;
			ended_q    <= 1'b0;
			div_den_q  <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;

			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lsfp_pkg::REG_BLACK_LEVEL) black_q <= cfg_data[0];
				if (cfg_index == lsfp_pkg::REG_ERROR_LIMIT) limit_q <= cfg_data;
			end

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				lsfp_pkg::ST_IDLE: begin
					if (s_acc) begin
						ended_q <= (s_tdata == lsfp_pkg::CH_HASH);
						if (s_tdata == lsfp_pkg::CH_HASH) begin
							len_q      <= '0;
							scan_len_q <= len_new;
							issue_q    <= '0;
							mode_q     <= lsfp_pkg::MD_HDR0;
							ch_q       <= '0;
							state_q    <= lsfp_pkg::ST_SCAN;
						end else begin
							len_q   <= len_new;
							state_q <= lsfp_pkg::ST_CALC;
						end
					end
				end
				lsfp_pkg::ST_SCAN: begin
					if (rd_en) issue_q <= issue_q + 1'b1;
					if (rd_vld_s1) begin
						mode_q   <= mode_d;
						levels_q <= lvl_d;
						if (ch_inc) ch_q <= ch_q + 3'd1;
						if (ev_stop) state_q <= lsfp_pkg::ST_CALC;
					end else if (issue_q == scan_len_q) begin
						state_q <= lsfp_pkg::ST_CALC;
					end
				end
				lsfp_pkg::ST_CALC: begin
					if (bcount == 4'd0) begin
						lost_q  <= 1'b1;
						state_q <= lsfp_pkg::ST_POST;
					end else begin
						lost_q    <= 1'b0;
						neg_q     <= (wsum < 0);
						div_den_q <= bcount;
						rem_q     <= '0;
						quot_q    <= {wsum_abs[4:0], {lsfp_pkg::FRAC_BITS{1'b0}}};
						div_cnt_q <= '0;
						state_q   <= lsfp_pkg::ST_DIV;
					end
				end
				lsfp_pkg::ST_DIV: begin
					rem_q     <= trial_ge ? trial_sub[3:0] : trial[3:0];
					quot_q    <= {quot_q[lsfp_pkg::NUM_W-2:0], trial_ge};
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == lsfp_pkg::DCNT_W'(lsfp_pkg::NUM_W - 1)) begin
						state_q <= lsfp_pkg::ST_POST;
					end
				end
				lsfp_pkg::ST_POST: begin
					if (out_load) begin
						if (!lost_q && (mag_c > lsfp_pkg::NUM_W'(lsfp_pkg::HOLD_THRESH))) begin
							held_q <= err_val;
						end
						state_q <= lsfp_pkg::ST_IDLE;
					end
				end
				default: state_q <= lsfp_pkg::ST_IDLE;
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {4'b0000, res_err, levels_q};
			m_tuser_q <= lost_q;
			m_tlast_q <= ended_q;
		end
	end

	assign out_err     = $signed(m_tdata[19:8]);
	assign out_err_mag = (out_err < 0) ? lsfp_pkg::ERR_W'(-out_err) : lsfp_pkg::ERR_W'(out_err);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_hash_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tdata == lsfp_pkg::CH_HASH) |=> state_q == lsfp_pkg::ST_SCAN)
		else $error("frame end byte did not start a store scan");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= lsfp_pkg::AW'(lsfp_pkg::FULL_LEN) && scan_len_q <= lsfp_pkg::AW'(lsfp_pkg::FULL_LEN))
		else $error("frame length beyond store capacity");

	a_div_den: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lsfp_pkg::ST_DIV) |-> (div_den_q != 4'd0 && div_den_q <= 4'd8))
		else $error("divider running with bad black count");

	a_err_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) && !m_tuser |-> out_err_mag <= lsfp_pkg::ERR_W'(limit_q))
		else $error("position error outside clamp limit");

endmodule
